FILE: sv/lsrc_pkg.sv
package lsrc_pkg;

    localparam int COORD_W         = 16;
    localparam int QBITS           = 16;
    localparam int QPS             = 4;
    localparam int DIV_STAGES      = QBITS / QPS;
    localparam int NSTEPS          = 8;
    localparam int STAGES_PER_STEP = DIV_STAGES + 2;
    localparam int LATENCY         = NSTEPS * STAGES_PER_STEP;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] REG_X_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_MAX = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = 2'd3;

    // [point][axis], point 0 = start, axis 0 = x
    typedef logic [1:0][1:0][COORD_W-1:0] pts_t;
    typedef logic [2:0] step_t;

    typedef struct packed {
        logic [1:0][COORD_W-1:0] lo;
        logic [1:0][COORD_W-1:0] hi;
    } rect_t;

    typedef struct packed {
        logic [COORD_W:0]   rem;
        logic [QBITS-1:0]   nlo;
        logic [QBITS-1:0]   q;
    } div_t;

    typedef struct packed {
        pts_t           orig;
        pts_t           cur;
        logic           rej;
        logic           move;
        logic           neg;
        logic [COORD_W:0] den;
        div_t           dv;
    } work_t;

    function automatic logic both_beyond(input pts_t c, input rect_t r);
        logic res;
        res = 1'b0;
        for (int ax = 0; ax < 2; ax++)
        begin
            if (($signed(c[0][ax]) < $signed(r.lo[ax]) && $signed(c[1][ax]) < $signed(r.lo[ax]))
                || ($signed(c[0][ax]) > $signed(r.hi[ax])
                    && $signed(c[1][ax]) > $signed(r.hi[ax])))
                res = 1'b1;
        end
        return res;
    endfunction

endpackage

FILE: sv/lsrc_ifs.sv
interface seg_if import lsrc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface res_if import lsrc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               visible;
    logic [COORD_W-1:0] clipped_start_x;
    logic [COORD_W-1:0] clipped_start_y;
    logic [COORD_W-1:0] clipped_end_x;
    logic [COORD_W-1:0] clipped_end_y;
    modport source (output valid, visible, clipped_start_x, clipped_start_y,
                    clipped_end_x, clipped_end_y, input ready);
    modport sink (input valid, visible, clipped_start_x, clipped_start_y,
                  clipped_end_x, clipped_end_y, output ready);
endinterface

interface cfg_if import lsrc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COORD_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/line_segment_rect_clipper.sv
// Pipeline: 8 steps x 6 stages (setup with multiply, four 4-bit divider stages,
// apply) between the input transfer and the result.
// Throughput: one segment per cycle; a stall on the result side freezes every stage.
// Reset: clears all stage valid bits and sets the clip rectangle to all zeros.
module line_segment_rect_clipper import lsrc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    seg_if.sink  seg,
    res_if.source res,
    cfg_if.sink  cfg
);

    rect_t          rect_reg;
    logic           en;
    logic [LATENCY:0] v;
    work_t          w [0:LATENCY];
    work_t          last;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rect_reg <= '0;
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_X_MIN: rect_reg.lo[0] <= cfg.data;
                REG_Y_MIN: rect_reg.lo[1] <= cfg.data;
                REG_X_MAX: rect_reg.hi[0] <= cfg.data;
                REG_Y_MAX: rect_reg.hi[1] <= cfg.data;
                default:   rect_reg <= rect_reg;
            endcase
        end
    end

    assign en        = ~v[LATENCY] | res.ready;
    assign seg.ready = en;

    always_comb
    begin
        w[0]            = '0;
        w[0].orig[0][0] = seg.start_x;
        w[0].orig[0][1] = seg.start_y;
        w[0].orig[1][0] = seg.end_x;
        w[0].orig[1][1] = seg.end_y;
        w[0].cur        = w[0].orig;
    end
    assign v[0] = seg.valid;

    for (genvar s = 0; s < NSTEPS; s++)
    begin : g_step
        for (genvar k = 0; k < STAGES_PER_STEP; k++)
        begin : g_stage
            localparam int J = s * STAGES_PER_STEP + k;
            if (k == 0)
            begin : g_setup
                lsrc_setup u_setup (
                    .clk(clk), .rst_n(rst_n), .en(en), .step(step_t'(s)),
                    .rect(rect_reg), .in_valid(v[J]), .in_work(w[J]),
                    .out_valid(v[J+1]), .out_work(w[J+1])
                );
            end
            else if (k == STAGES_PER_STEP - 1)
            begin : g_apply
                lsrc_apply u_apply (
                    .clk(clk), .rst_n(rst_n), .en(en), .step(step_t'(s)),
                    .rect(rect_reg), .in_valid(v[J]), .in_work(w[J]),
                    .out_valid(v[J+1]), .out_work(w[J+1])
                );
            end
            else
            begin : g_div
                lsrc_div u_div (
                    .clk(clk), .rst_n(rst_n), .en(en),
                    .in_valid(v[J]), .in_work(w[J]),
                    .out_valid(v[J+1]), .out_work(w[J+1])
                );
            end
        end
    end

    assign last                = w[LATENCY];
    assign res.valid           = v[LATENCY];
    assign res.visible         = ~last.rej;
    assign res.clipped_start_x = last.rej ? last.orig[0][0] : last.cur[0][0];
    assign res.clipped_start_y = last.rej ? last.orig[0][1] : last.cur[0][1];
    assign res.clipped_end_x   = last.rej ? last.orig[1][0] : last.cur[1][0];
    assign res.clipped_end_y   = last.rej ? last.orig[1][1] : last.cur[1][1];

    // frozen pipe keeps every stage's occupancy
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v[LATENCY:1]))
        else $error("stage valid bits changed during stall");

    // a visible result's start x and end y lie inside a proper rectangle
    a_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.visible
         && $signed(rect_reg.lo[0]) <= $signed(rect_reg.hi[0])
         && $signed(rect_reg.lo[1]) <= $signed(rect_reg.hi[1]))
        |-> ($signed(res.clipped_start_x) >= $signed(rect_reg.lo[0])
             && $signed(res.clipped_start_x) <= $signed(rect_reg.hi[0])
             && $signed(res.clipped_end_y) >= $signed(rect_reg.lo[1])
             && $signed(res.clipped_end_y) <= $signed(rect_reg.hi[1])))
        else $error("visible segment outside clip rectangle");

endmodule

FILE: sv/lsrc_setup.sv
module lsrc_setup import lsrc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  step_t step,
    input  rect_t rect,
    input  logic  in_valid,
    input  work_t in_work,
    output logic  out_valid,
    output work_t out_work
);

    logic                     axis, plane, pt;
    logic signed [COORD_W-1:0] p1a, p2a, p1o, p2o, pv;
    logic signed [COORD_W:0]   d1, d2, diff;
    logic signed [COORD_W+1:0] den, den_mag;
    logic signed [2*COORD_W+1:0] prod, mag;
    logic                     rej_n;
    logic                     valid_reg;
    work_t                    work_reg, work_next;

    always_comb
    begin
        axis  = step[2];
        plane = step[1];
        pt    = step[0];
        p1a   = $signed(in_work.cur[pt][axis]);
        p2a   = $signed(in_work.cur[~pt][axis]);
        p1o   = $signed(in_work.cur[pt][~axis]);
        p2o   = $signed(in_work.cur[~pt][~axis]);
        pv    = plane ? $signed(rect.hi[axis]) : $signed(rect.lo[axis]);
        // signed distance to the plane, negative when outside
        d1    = plane ? (17'(pv) - 17'(p1a)) : (17'(p1a) - 17'(pv));
        d2    = plane ? (17'(pv) - 17'(p2a)) : (17'(p2a) - 17'(pv));
        den   = 18'(d1) - 18'(d2);
        den_mag = den[COORD_W+1] ? -den : den;
        diff  = 17'(p2o) - 17'(p1o);
        prod  = 34'(diff) * 34'(d1);
        mag   = prod[2*COORD_W+1] ? -prod : prod;
        rej_n = in_work.rej | both_beyond(in_work.cur, rect);

        work_next         = in_work;
        work_next.rej     = rej_n;
        work_next.move    = !rej_n && (d1 < 17'sd0) && (den != 18'sd0);
        work_next.neg     = prod[2*COORD_W+1] ^ den[COORD_W+1];
        work_next.den     = den_mag[COORD_W:0];
        // quotient fits QBITS, so the top part starts below den
        work_next.dv.rem  = {1'b0, mag[2*COORD_W-1:QBITS]};
        work_next.dv.nlo  = mag[QBITS-1:0];
        work_next.dv.q    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            work_reg <= work_next;
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

FILE: sv/lsrc_div.sv
module lsrc_div import lsrc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  work_t in_work,
    output logic  out_valid,
    output work_t out_work
);

    logic             valid_reg;
    work_t            work_reg, work_next;
    logic [COORD_W+1:0] t;
    logic [COORD_W+1:0] dext;
    logic             ge;

    // restoring division, QPS quotient bits per stage
    always_comb
    begin
        work_next = in_work;
        dext      = {1'b0, in_work.den};
        t         = '0;
        ge        = 1'b0;
        for (int i = 0; i < QPS; i++)
        begin
            t  = {work_next.dv.rem, work_next.dv.nlo[QBITS-1]};
            ge = (t >= dext);
            work_next.dv.rem = ge ? 17'(t - dext) : t[COORD_W:0];
            work_next.dv.nlo = {work_next.dv.nlo[QBITS-2:0], 1'b0};
            work_next.dv.q   = {work_next.dv.q[QBITS-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            work_reg <= work_next;
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

FILE: sv/lsrc_apply.sv
module lsrc_apply import lsrc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  step_t step,
    input  rect_t rect,
    input  logic  in_valid,
    input  work_t in_work,
    output logic  out_valid,
    output work_t out_work
);

    logic               axis, plane, pt;
    logic [COORD_W:0]   qs;
    logic [COORD_W-1:0] pv;
    logic               valid_reg;
    work_t              work_reg, work_next;

    always_comb
    begin
        axis      = step[2];
        plane     = step[1];
        pt        = step[0];
        pv        = plane ? rect.hi[axis] : rect.lo[axis];
        qs        = in_work.neg ? -17'(in_work.dv.q) : 17'(in_work.dv.q);
        work_next = in_work;
        if (in_work.move)
        begin
            work_next.cur[pt][~axis] = in_work.cur[pt][~axis] + qs[COORD_W-1:0];
            work_next.cur[pt][axis]  = pv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            work_reg <= work_next;
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

FILE: test/tb_top.sv
module tb_top;
    import lsrc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic            visible;
        logic [15:0]     sx;
        logic [15:0]     sy;
        logic [15:0]     ex;
        logic [15:0]     ey;
    } clip_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    seg_if seg ();
    res_if res ();
    cfg_if cfg ();

    line_segment_rect_clipper u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .seg   (seg.sink),
        .res   (res.source),
        .cfg   (cfg.sink)
    );

    always #4 clk = ~clk;

    // clip rectangle as seen by the predictor: [axis]
    int rect_lo [2];
    int rect_hi [2];

    clip_res_t pending_clips [$];
    int  mismatch_cnt = 0;
    int  idle_cycles = 0;
    bit  timed_out = 1'b0;
    bit  rx_stall_en = 1'b1;

    localparam int WATCHDOG_LIMIT = 20000;

    function automatic bit outside_same_side(int pt [2][2]);
        for (int ax = 0; ax < 2; ax++)
        begin
            if (pt[0][ax] < rect_lo[ax] && pt[1][ax] < rect_lo[ax])
                return 1'b1;
            if (pt[0][ax] > rect_hi[ax] && pt[1][ax] > rect_hi[ax])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic clip_res_t clip_segment(logic [15:0] sx, logic [15:0] sy,
                                               logic [15:0] ex, logic [15:0] ey);
        int        pt [2][2];
        bit        rej;
        int        pv;
        int        me;
        int        oth;
        int        nrm;
        longint    d1;
        longint    d2;
        longint    den;
        longint    num;
        clip_res_t r;
        pt[0][0] = $signed(sx);
        pt[0][1] = $signed(sy);
        pt[1][0] = $signed(ex);
        pt[1][1] = $signed(ey);
        rej = 1'b0;
        for (int ax = 0; ax < 2 && !rej; ax++)
        begin
            for (int pl = 0; pl < 2 && !rej; pl++)
            begin
                for (int p = 0; p < 2; p++)
                begin
                    if (outside_same_side(pt))
                    begin
                        rej = 1'b1;
                        break;
                    end
                    me  = p;
                    oth = 1 - p;
                    nrm = (pl == 0) ? 1 : -1;
                    pv  = (pl == 0) ? rect_lo[ax] : rect_hi[ax];
                    if ((pl == 0) ? (pt[me][ax] >= pv) : (pt[me][ax] <= pv))
                        continue;
                    d1  = nrm * (longint'(pt[me][ax]) - pv);
                    d2  = nrm * (longint'(pt[oth][ax]) - pv);
                    den = d1 - d2;
                    if (den == 0)
                        continue;
                    num = (longint'(pt[oth][1-ax]) - pt[me][1-ax]) * d1;
                    // SV division truncates toward zero, same as the hardware
                    pt[me][1-ax] = pt[me][1-ax] + int'(num / den);
                    pt[me][ax]   = pv;
                end
            end
        end
        if (rej)
        begin
            r.visible = 1'b0;
            r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey;
        end
        else
        begin
            r.visible = 1'b1;
            r.sx = pt[0][0][15:0];
            r.sy = pt[0][1][15:0];
            r.ex = pt[1][0][15:0];
            r.ey = pt[1][1][15:0];
        end
        return r;
    endfunction

    // valid stays high after the transfer; the drain, or a next call that waits a gap, drops it
    task automatic send_segment(logic [15:0] sx, logic [15:0] sy,
                                logic [15:0] ex, logic [15:0] ey);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            seg.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        seg.valid   <= 1'b1;
        seg.start_x <= sx;
        seg.start_y <= sy;
        seg.end_x   <= ex;
        seg.end_y   <= ey;
        @(posedge clk);
        while (!seg.ready)
            @(posedge clk);
        pending_clips.push_back(clip_segment(sx, sy, ex, ey));
        @(negedge clk);
    endtask

    task automatic write_bound(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        if (idx == REG_X_MIN) rect_lo[0] = $signed(val);
        if (idx == REG_Y_MIN) rect_lo[1] = $signed(val);
        if (idx == REG_X_MAX) rect_hi[0] = $signed(val);
        if (idx == REG_Y_MAX) rect_hi[1] = $signed(val);
        @(negedge clk);
    endtask

    task automatic set_rect(int xl, int yl, int xh, int yh);
        write_bound(REG_X_MIN, xl[15:0]);
        write_bound(REG_Y_MIN, yl[15:0]);
        write_bound(REG_X_MAX, xh[15:0]);
        write_bound(REG_Y_MAX, yh[15:0]);
        cfg.valid <= 1'b0;
    endtask

    task automatic drain_pipeline();
        seg.valid <= 1'b0;
        while (pending_clips.size() != 0 && !timed_out)
            @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
    endtask

    function automatic logic [15:0] pick_coord();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 16'h8000;
        if (k == 1)
            return 16'h7fff;
        if (k < 5)
            return 16'($urandom());
        return 16'($signed(rect_lo[k % 2]) + $signed($urandom_range(0, 600)) - 200);
    endfunction

    task automatic test_reset_rect();
        // zero-sized rectangle at the origin
        send_segment(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_segment(16'hfff6, 16'hfff6, 16'h000a, 16'h000a);
        send_segment(16'h0001, 16'h0005, 16'h0003, 16'hfffb);
        drain_pipeline();
    endtask

    task automatic test_directed();
        set_rect(-100, -50, 100, 50);
        send_segment(16'd0, 16'd0, 16'd10, 16'd10);                   // fully inside
        send_segment(16'hff00, 16'd0, 16'hff10, 16'd20);              // both left
        send_segment(16'd200, 16'd0, 16'd300, 16'd0);                 // both right
        send_segment(16'd0, 16'hff00, 16'd10, 16'hff01);              // both above
        send_segment(16'd0, 16'd60, 16'd10, 16'd90);                  // both below
        send_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);         // extremes, crosses
        send_segment(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        send_segment(16'h8000, 16'd0, 16'h7fff, 16'd0);               // horizontal
        send_segment(16'd0, 16'h8000, 16'd0, 16'h7fff);               // vertical
        send_segment(16'hff38, 16'hffec, 16'd0, 16'd70);              // clipped at both ends
        send_segment(16'd150, 16'd0, 16'd0, 16'd80);                  // cuts the corner, clipped at both ends
        send_segment(16'hff9c, 16'hffce, 16'd100, 16'd50);            // on corners
        drain_pipeline();
        set_rect(-32768, -32768, 32767, 32767);
        send_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        send_segment(16'h1234, 16'hedcb, 16'h8000, 16'h7fff);
        drain_pipeline();
        // inverted rectangle
        set_rect(100, 100, -100, -100);
        send_segment(16'd0, 16'd0, 16'd0, 16'd0);
        send_segment(16'hff00, 16'hff00, 16'd256, 16'd256);
        send_segment(16'd150, 16'hff00, 16'hff00, 16'd150);
        drain_pipeline();
    endtask

    task automatic test_random(int rects, int per_rect);
        int xl, yl, w, h;
        for (int r = 0; r < rects; r++)
        begin
            if (r % 3 == 0)
                set_rect($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                         $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
            else
            begin
                xl = int'($urandom_range(0, 2000)) - 1000;
                yl = int'($urandom_range(0, 2000)) - 1000;
                w  = $urandom_range(0, 400);
                h  = $urandom_range(0, 400);
                set_rect(xl, yl, xl + w, yl + h);
            end
            rx_stall_en = (r % 4 != 1);
            for (int i = 0; i < per_rect; i++)
                send_segment(pick_coord(), pick_coord(), pick_coord(), pick_coord());
            drain_pipeline();
        end
        rx_stall_en = 1'b1;
    endtask

    // result side: random stalls while rx_stall_en is set, compare against oldest expectation
    initial
    begin
        int        stall;
        clip_res_t exp_r;
        res.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = rx_stall_en ? $urandom_range(0, 7) : 0;
            if ($urandom_range(0, 2) == 0)
                stall = 0;
            if (stall != 0)
            begin
                res.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res.ready <= 1'b1;
            @(posedge clk);
            while (!res.valid)
                @(posedge clk);
            if (pending_clips.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result transfer: vis=%0b %h %h %h %h", res.visible,
                             res.clipped_start_x, res.clipped_start_y,
                             res.clipped_end_x, res.clipped_end_y);
            end
            else
            begin
                exp_r = pending_clips.pop_front();
                if (res.visible !== exp_r.visible || res.clipped_start_x !== exp_r.sx
                    || res.clipped_start_y !== exp_r.sy || res.clipped_end_x !== exp_r.ex
                    || res.clipped_end_y !== exp_r.ey)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp vis=%0b %h %h %h %h got vis=%0b %h %h %h %h",
                                 exp_r.visible, exp_r.sx, exp_r.sy, exp_r.ex, exp_r.ey,
                                 res.visible, res.clipped_start_x, res.clipped_start_y,
                                 res.clipped_end_x, res.clipped_end_y);
                end
            end
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge clk)
    begin
        if ((seg.valid && seg.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            timed_out = 1'b1;
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        seg.valid   <= 1'b0;
        seg.start_x <= '0;
        seg.start_y <= '0;
        seg.end_x   <= '0;
        seg.end_y   <= '0;
        cfg.valid   <= 1'b0;
        cfg.index   <= REG_X_MIN;
        cfg.data    <= '0;
        rect_lo = '{0, 0};
        rect_hi = '{0, 0};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_rect();
        test_directed();
        test_random(15, 30);
        if (pending_clips.size() != 0)
            mismatch_cnt++;
        if (mismatch_cnt == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
